### sv/astx247_pkg.sv
// Shared types and constants for the category 247 record decoder.
// Used by the parser, the command queue, the result sequencer and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package astx247_pkg;

   // Category number that a message must carry in its first byte.
   localparam logic [7:0] CATEGORY_CODE = 8'd247;

   // Default depth of the command queue between parser and sequencer.
   localparam int QUEUE_DEPTH = 4;

   // Result kinds as they appear on the result channel.
   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_ENTRY  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // Error codes carried by an error result.
   localparam logic [1:0] ERR_WRONG_CATEGORY = 2'd0;
   localparam logic [1:0] ERR_SHORT_BUFFER   = 2'd1;
   localparam logic [1:0] ERR_EXTENDED_FSPEC = 2'd2;
   localparam logic [1:0] ERR_RECORD_OVERRUN = 2'd3;

   // Width of the packed result data word.
   localparam int RSP_DATA_W = 80;

   // One queue entry: every result that a single input byte causes.
   typedef struct packed {
      logic        has_entry;
      logic        has_record;
      logic        has_end;
      logic        end_ok;
      logic [1:0]  err_code;
      logic [7:0]  category_code;
      logic [7:0]  main_version;
      logic [7:0]  sub_version;
      logic [7:0]  source_area;
      logic [7:0]  source_id;
      logic        time_seen;
      logic [23:0] time_raw;
      logic [7:0]  entry_count;
   } cmd_type;

   // One result as held in the output register.
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  source_area;
      logic [7:0]  source_id;
      logic        time_present;
      logic [26:0] time_ms;
      logic [7:0]  entry_count;
      logic [7:0]  category_code;
      logic [7:0]  main_version;
      logic [7:0]  sub_version;
      logic [1:0]  error_code;
      logic        last_result;
   } rsp_type;

endpackage

`default_nettype wire

### sv/astx247_front.sv
// Byte parser of the category 247 record decoder: message and record state machine.
// Classifies each accepted byte and builds one queue command per byte with results.
// Depends on astx247_pkg.
`timescale 1ns / 1ps
`default_nettype none

module astx247_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  wire [7:0]             byte_value,
   input  wire                   last_byte,
   output logic                  push,
   output astx247_pkg::cmd_type  cmd
);

   // Parser phases.
   localparam logic [3:0] PH_CAT   = 4'd0;
   localparam logic [3:0] PH_LENH  = 4'd1;
   localparam logic [3:0] PH_LENL  = 4'd2;
   localparam logic [3:0] PH_FSPEC = 4'd3;
   localparam logic [3:0] PH_SRC   = 4'd4;
   localparam logic [3:0] PH_SERV  = 4'd5;
   localparam logic [3:0] PH_TIME  = 4'd6;
   localparam logic [3:0] PH_REP   = 4'd7;
   localparam logic [3:0] PH_ENTRY = 4'd8;
   localparam logic [3:0] PH_DRAIN = 4'd9;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  spec_ff, spec_in;
   logic [1:0]  fidx_ff, fidx_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  total_ff, total_in;
   logic [7:0]  area_ff, area_in;
   logic [7:0]  ident_ff, ident_in;
   logic [23:0] time_ff, time_in;
   logic        tseen_ff, tseen_in;
   logic [15:0] ebytes_ff, ebytes_in;
   logic        in_record;

   // Phase of the first present field at or after slot k; PH_FSPEC closes the record.
   function automatic logic [3:0] field_phase(input logic [7:0] spec, input logic [2:0] k);
      logic [3:0] ph;
      ph = PH_FSPEC;
      for (int i = 3; i >= 0; i--) begin
         if (int'(k) <= i && spec[7 - i]) begin
            ph = PH_SRC + 4'(i);
         end
      end
      return ph;
   endfunction

   // Next state and command for the byte on the input.
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      spec_in   = spec_ff;
      fidx_in   = fidx_ff;
      left_in   = left_ff;
      total_in  = total_ff;
      area_in   = area_ff;
      ident_in  = ident_ff;
      time_in   = time_ff;
      tseen_in  = tseen_ff;
      ebytes_in = ebytes_ff;
      in_record = 1'b0;
      cmd       = '0;

      case (phase_ff)
         PH_CAT: begin
            pos_in = 16'd1;
            if (byte_value != astx247_pkg::CATEGORY_CODE) begin
               cmd.has_end  = 1'b1;
               cmd.err_code = astx247_pkg::ERR_WRONG_CATEGORY;
               phase_in     = PH_DRAIN;
            end else begin
               phase_in = PH_LENH;
            end
         end
         PH_LENH: begin
            pos_in   = 16'd2;
            len_in   = {byte_value, 8'h00};
            phase_in = PH_LENL;
         end
         PH_LENL: begin
            pos_in = 16'd3;
            len_in = {len_ff[15:8], byte_value};
            if (len_in <= 16'd3) begin
               cmd.has_end = 1'b1;
               cmd.end_ok  = 1'b1;
               phase_in    = PH_DRAIN;
            end else begin
               phase_in = PH_FSPEC;
            end
         end
         PH_FSPEC: begin
            in_record = 1'b1;
            spec_in   = byte_value;
            area_in   = 8'd0;
            ident_in  = 8'd0;
            time_in   = 24'd0;
            tseen_in  = 1'b0;
            total_in  = 8'd0;
            left_in   = 8'd0;
            if (byte_value[0]) begin
               // Extended field specifications are not supported.
               if (!last_byte) begin
                  cmd.has_end  = 1'b1;
                  cmd.err_code = astx247_pkg::ERR_EXTENDED_FSPEC;
               end
               phase_in = PH_DRAIN;
            end else begin
               fidx_in  = 2'd0;
               phase_in = field_phase(byte_value, 3'd0);
               cmd.has_record = (phase_in == PH_FSPEC);
            end
         end
         PH_SRC: begin
            in_record = 1'b1;
            if (fidx_ff == 2'd0) begin
               area_in = byte_value;
               fidx_in = 2'd1;
            end else begin
               ident_in = byte_value;
               fidx_in  = 2'd0;
               phase_in = field_phase(spec_ff, 3'd1);
               cmd.has_record = (phase_in == PH_FSPEC);
            end
         end
         PH_SERV: begin
            in_record = 1'b1;
            fidx_in   = 2'd0;
            phase_in  = field_phase(spec_ff, 3'd2);
            cmd.has_record = (phase_in == PH_FSPEC);
         end
         PH_TIME: begin
            in_record = 1'b1;
            time_in   = {time_ff[15:0], byte_value};
            if (fidx_ff >= 2'd2) begin
               tseen_in = 1'b1;
               fidx_in  = 2'd0;
               phase_in = field_phase(spec_ff, 3'd3);
               cmd.has_record = (phase_in == PH_FSPEC);
            end else begin
               fidx_in = fidx_ff + 2'd1;
            end
         end
         PH_REP: begin
            in_record = 1'b1;
            total_in  = byte_value;
            left_in   = byte_value;
            fidx_in   = 2'd0;
            if (byte_value == 8'd0) begin
               phase_in       = PH_FSPEC;
               cmd.has_record = 1'b1;
            end else begin
               phase_in = PH_ENTRY;
            end
         end
         PH_ENTRY: begin
            in_record = 1'b1;
            if (fidx_ff == 2'd0) begin
               ebytes_in = {byte_value, 8'h00};
               fidx_in   = 2'd1;
            end else if (fidx_ff == 2'd1) begin
               ebytes_in = {ebytes_ff[15:8], byte_value};
               fidx_in   = 2'd2;
            end else begin
               // Third byte completes a version entry.
               cmd.has_entry     = 1'b1;
               cmd.category_code = ebytes_ff[15:8];
               cmd.main_version  = ebytes_ff[7:0];
               cmd.sub_version   = byte_value;
               fidx_in           = 2'd0;
               left_in           = left_ff - 8'd1;
               if (left_in == 8'd0) begin
                  phase_in       = PH_FSPEC;
                  cmd.has_record = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_DRAIN;
         end
      endcase

      // Record contents as they stand after this byte.
      cmd.source_area = area_in;
      cmd.source_id   = ident_in;
      cmd.time_seen   = tseen_in;
      cmd.time_raw    = time_in;
      cmd.entry_count = total_in;

      // Message length checks inside the record area.
      if (in_record) begin
         pos_in = pos_ff + 16'd1;
         if (phase_in != PH_DRAIN && pos_in >= len_ff) begin
            cmd.has_end = 1'b1;
            if (phase_in == PH_FSPEC) begin
               cmd.end_ok = 1'b1;
            end else begin
               cmd.err_code = astx247_pkg::ERR_RECORD_OVERRUN;
            end
            phase_in = PH_DRAIN;
         end else if (phase_in == PH_DRAIN && last_byte && !cmd.has_end) begin
            // Extended specification on the final byte reports a short buffer.
            cmd.has_end  = 1'b1;
            cmd.err_code = astx247_pkg::ERR_SHORT_BUFFER;
         end
      end

      // Buffer ended before the message did.
      if (phase_in != PH_DRAIN && last_byte) begin
         cmd.has_end  = 1'b1;
         cmd.err_code = astx247_pkg::ERR_SHORT_BUFFER;
         phase_in     = PH_DRAIN;
      end

      // The byte after the last one starts a new message.
      if (phase_in == PH_DRAIN && last_byte) begin
         phase_in  = PH_CAT;
         pos_in    = 16'd0;
         len_in    = 16'd0;
         spec_in   = 8'd0;
         fidx_in   = 2'd0;
         left_in   = 8'd0;
         total_in  = 8'd0;
         area_in   = 8'd0;
         ident_in  = 8'd0;
         time_in   = 24'd0;
         tseen_in  = 1'b0;
         ebytes_in = 16'd0;
      end

      push = accept && (cmd.has_entry || cmd.has_record || cmd.has_end);
   end

   // Parser state registers, updated once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CAT;
         pos_ff    <= 16'd0;
         len_ff    <= 16'd0;
         spec_ff   <= 8'd0;
         fidx_ff   <= 2'd0;
         left_ff   <= 8'd0;
         total_ff  <= 8'd0;
         area_ff   <= 8'd0;
         ident_ff  <= 8'd0;
         time_ff   <= 24'd0;
         tseen_ff  <= 1'b0;
         ebytes_ff <= 16'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         spec_ff   <= spec_in;
         fidx_ff   <= fidx_in;
         left_ff   <= left_in;
         total_ff  <= total_in;
         area_ff   <= area_in;
         ident_ff  <= ident_in;
         time_ff   <= time_in;
         tseen_ff  <= tseen_in;
         ebytes_ff <= ebytes_in;
      end
   end

endmodule

`default_nettype wire

### sv/astx247_fifo.sv
// Command queue between the byte parser and the result sequencer.
// A small register FIFO with a combinational head read.
// Depends on astx247_pkg.
`timescale 1ns / 1ps
`default_nettype none

module astx247_fifo #(
   parameter int DEPTH = astx247_pkg::QUEUE_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  astx247_pkg::cmd_type  push_data,
   input  wire                   pop,
   output astx247_pkg::cmd_type  head_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   astx247_pkg::cmd_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = store_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // Pointer and fill count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/astx247_back.sv
// Result sequencer of the category 247 record decoder.
// Expands each queue command into entry, record and end results, one per cycle unless the receiver stalls.
// Depends on astx247_pkg.
`timescale 1ns / 1ps
`default_nettype none

module astx247_back (
   input  wire                   clock,
   input  wire                   reset,
   input  astx247_pkg::cmd_type  head,
   input  wire                   empty,
   output logic                  pop,
   input  wire                   rsp_ready,
   output logic                  rsp_valid,
   output astx247_pkg::rsp_type  rsp
);

   logic [2:0]  sent_ff, sent_in;
   logic [2:0]  pend;
   logic [2:0]  sel;
   logic        is_last;
   logic        load;
   logic        out_valid_ff, out_valid_in;
   logic [33:0] time_prod;
   astx247_pkg::rsp_type out_ff, out_in;

   // Results of the head command still to be sent, entry first, then record, then end.
   assign pend    = {head.has_end, head.has_record, head.has_entry} & ~sent_ff;
   assign sel     = pend[0] ? 3'b001 : (pend[1] ? 3'b010 : 3'b100);
   assign is_last = ((pend & (pend - 3'd1)) == 3'd0);
   assign load    = !empty && (!out_valid_ff || rsp_ready);
   assign pop     = load && is_last;

   // Time of day times 1000 as shifts: 1000 = 1024 - 16 - 8.
   assign time_prod = ({10'd0, head.time_raw} << 10) - ({10'd0, head.time_raw} << 4)
                      - ({10'd0, head.time_raw} << 3);

   // Build the selected result.
   always_comb begin
      out_in             = '0;
      out_in.last_result = is_last;
      if (sel[0]) begin
         out_in.result_kind   = astx247_pkg::KIND_ENTRY;
         out_in.category_code = head.category_code;
         out_in.main_version  = head.main_version;
         out_in.sub_version   = head.sub_version;
      end else if (sel[1]) begin
         out_in.result_kind  = astx247_pkg::KIND_RECORD;
         out_in.source_area  = head.source_area;
         out_in.source_id    = head.source_id;
         out_in.time_present = head.time_seen;
         out_in.time_ms      = head.time_seen ? time_prod[33:7] : 27'd0;
         out_in.entry_count  = head.entry_count;
      end else begin
         out_in.result_kind = head.end_ok ? astx247_pkg::KIND_DONE : astx247_pkg::KIND_ERROR;
         out_in.error_code  = head.end_ok ? 2'd0 : head.err_code;
      end
   end

   // Sent mask and output valid.
   always_comb begin
      sent_in = sent_ff;
      if (pop) begin
         sent_in = 3'd0;
      end else if (load) begin
         sent_in = sent_ff | sel;
      end
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

`default_nettype wire

### sv/asterix_cat247_record_decoder.sv
// Top level of the category 247 (version number report) record decoder.
// Instantiates the byte parser, the command queue and the result sequencer.
// Depends on astx247_pkg, astx247_front, astx247_fifo and astx247_back.
//
// Usage: message bytes enter on the req_ stream, one byte per transaction, header
// first; req_tlast marks the final byte of the supplied buffer. Results leave on the
// rsp_ stream: one per version entry, one per record and one at message end (done or
// error); rsp_tuser gives the kind and rsp_tlast marks the last result of one byte.
// Throughput: one input byte per cycle while the command queue is not full. The result
// sequencer sends the results of a byte one after another, at most three of them; the
// command queue of QUEUE_DEPTH entries absorbs these bursts. The accepting clock edge
// writes the command into the queue; the sequencer then loads each result into the
// output register, from which it is valid on rsp_. Further results of the same byte
// follow one per cycle unless the receiver stalls. Reset clears the parser to wait
// for a category byte and empties the queue and the output register. When the
// receiver stalls, the output register holds its result, the queue fills, and
// req_tready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module asterix_cat247_record_decoder #(
   parameter int QUEUE_DEPTH = astx247_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] byte_value
   input  wire         req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // rsp_tdata from bit 0: source_area[7:0], source_id[15:8], time_present[16],
   // time_ms[43:17], entry_count[51:44], category_code[59:52], main_version[67:60],
   // sub_version[75:68], error_code[77:76], zero fill[79:78]
   output logic [astx247_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // last_result
);

   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 q_full;
   logic                 q_empty;
   astx247_pkg::cmd_type cmd;
   astx247_pkg::cmd_type head;
   astx247_pkg::rsp_type rsp;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Byte parser.
   astx247_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_tdata),
      .last_byte  (req_tlast),
      .push       (push),
      .cmd        (cmd)
   );

   // Command queue.
   astx247_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd),
      .pop       (pop),
      .head_data (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Result sequencer.
   astx247_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   // Pack the result fields onto the stream.
   assign rsp_tdata = {2'b00, rsp.error_code, rsp.sub_version, rsp.main_version,
                       rsp.category_code, rsp.entry_count, rsp.time_ms, rsp.time_present,
                       rsp.source_id, rsp.source_area};
   assign rsp_tuser = rsp.result_kind;
   assign rsp_tlast = rsp.last_result;

`ifndef SYNTHESIS
   // A message end result is always the last result of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == astx247_pkg::KIND_DONE ||
                     rsp_tuser == astx247_pkg::KIND_ERROR) |-> rsp_tlast)
      else $error("end result without last marker");

   // Only error results carry an error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != astx247_pkg::KIND_ERROR |-> rsp.error_code == 2'd0)
      else $error("error code on a non-error result");

   // A time value is reported only when the record carried a time of day.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.time_present |-> rsp.time_ms == 27'd0)
      else $error("time value without time of day");
`endif

endmodule

`default_nettype wire
